### sv/tfcf_pkg.sv
// ----------------------------------------------------------------------------
// tfcf_pkg
// Shared types, register indexes and constants for the touch frame filter.
// ----------------------------------------------------------------------------
package tfcf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_HALF_TURN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_MAX_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_MAX_Y     = 3'd4;

    localparam logic [7:0]  CONFIRM_RESET = 8'd2;
    localparam logic [15:0] GAP_RESET     = 16'd40;
    localparam logic [7:0]  RUN_MAX       = 8'd255;

    // status byte layout
    localparam int ST_FRESH_BIT = 7;
    localparam int ST_LARGE_BIT = 6;
    localparam logic [3:0] ST_COUNT_MASK = 4'hF;

    typedef struct packed {
        logic [7:0]  confirm_frames;
        logic [15:0] gap_limit_ms;
        logic        rotate_half_turn;
        logic [15:0] rotate_max_x;
        logic [15:0] rotate_max_y;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [31:0] now_ms;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] point_size;
    } t_item;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [31:0] last_frame_time;
        logic [15:0] held_x;
        logic [15:0] held_y;
        logic [15:0] held_size;
        logic        held_down;
        logic [31:0] rejected_counter;
        logic [31:0] frame_counter;
    } t_state;

    typedef struct packed {
        logic        frame_taken;
        logic        changed;
        logic        touch_down;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
        logic [15:0] touch_size;
        logic [3:0]  raw_count;
        logic        large_flag;
        logic [31:0] rejected_total;
        logic [31:0] frames_total;
    } t_result;

    // mirror with clamp at zero
    function automatic logic [15:0] mirror(input logic [15:0] v, input logic [15:0] ext);
        return (ext > v) ? (ext - v) : 16'd0;
    endfunction

endpackage

### sv/touch_frame_confirm_filter.sv
// ----------------------------------------------------------------------------
// touch_frame_confirm_filter
// Phantom-touch filter for polled touch controller frames.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one polled frame per beat
// (status byte, timestamp, first point). Output channel: o_out_valid /
// i_out_stall carry exactly one result beat per input beat, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index;
// write only while no beat is in flight.
// Path: a frame passes the input register, then the update logic into the
// result register, where filter state also updates, to become the result beat.
// Throughput: one frame per cycle while the result register is free or emptying.
// A finished result may wait in the output register while the next frame is
// taken into the input register; o_in_stall rises only while both registers
// are full and i_out_stall is high.
// Reset (synchronous, i_rst_n low) empties both registers, clears the run,
// held point and counters, and loads the register defaults.
// ----------------------------------------------------------------------------
module touch_frame_confirm_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tfcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfcf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_status_byte,
    input  logic [31:0]                      i_now_ms,
    input  logic [15:0]                      i_point_x,
    input  logic [15:0]                      i_point_y,
    input  logic [15:0]                      i_point_size,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_frame_taken,
    output logic                             o_changed,
    output logic                             o_touch_down,
    output logic [15:0]                      o_touch_x,
    output logic [15:0]                      o_touch_y,
    output logic [15:0]                      o_touch_size,
    output logic [3:0]                       o_raw_count,
    output logic                             o_large_flag,
    output logic [31:0]                      o_rejected_total,
    output logic [31:0]                      o_frames_total
);
    import tfcf_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    advance;
    logic    in_fire;

    tfcf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tfcf_update u_update (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // result register free or being emptied this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.status_byte <= i_status_byte;
            r_item.now_ms      <= i_now_ms;
            r_item.point_x     <= i_point_x;
            r_item.point_y     <= i_point_y;
            r_item.point_size  <= i_point_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_taken    = r_result.frame_taken;
    assign o_changed        = r_result.changed;
    assign o_touch_down     = r_result.touch_down;
    assign o_touch_x        = r_result.touch_x;
    assign o_touch_y        = r_result.touch_y;
    assign o_touch_size     = r_result.touch_size;
    assign o_raw_count      = r_result.raw_count;
    assign o_large_flag     = r_result.large_flag;
    assign o_rejected_total = r_result.rejected_total;
    assign o_frames_total   = r_result.frames_total;

endmodule

### sv/tfcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfcf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tfcf_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tfcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfcf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tfcf_pkg::t_cfg                   o_cfg
);
    import tfcf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONFIRM_FRAMES:   n_cfg.confirm_frames   = i_cfg_data[7:0];
                CFG_GAP_LIMIT_MS:     n_cfg.gap_limit_ms     = i_cfg_data;
                CFG_ROTATE_HALF_TURN: n_cfg.rotate_half_turn = i_cfg_data[0];
                CFG_ROTATE_MAX_X:     n_cfg.rotate_max_x     = i_cfg_data;
                CFG_ROTATE_MAX_Y:     n_cfg.rotate_max_y     = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_frames   <= CONFIRM_RESET;
            r_cfg.gap_limit_ms     <= GAP_RESET;
            r_cfg.rotate_half_turn <= 1'b0;
            r_cfg.rotate_max_x     <= 16'd0;
            r_cfg.rotate_max_y     <= 16'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/tfcf_update.sv
// ----------------------------------------------------------------------------
// tfcf_update
// Single-pass frame update: gap test, run tracking, confirm, mirror, change.
// ----------------------------------------------------------------------------
module tfcf_update (
    input  tfcf_pkg::t_cfg     i_cfg,
    input  tfcf_pkg::t_state   i_state,
    input  tfcf_pkg::t_item    i_item,
    output tfcf_pkg::t_state   o_state,
    output tfcf_pkg::t_result  o_result
);
    import tfcf_pkg::*;

    logic        fresh;
    logic [3:0]  raw;
    logic        large_bit;
    logic [7:0]  conf_eff;
    logic [31:0] gap;
    logic        gap_end;
    logic [7:0]  run_a;
    logic [7:0]  run_b;
    logic        rej_gap;
    logic        rej_rel;
    logic        down;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] ns;
    logic        chg;

    always_comb begin
        fresh     = i_item.status_byte[ST_FRESH_BIT];
        raw       = i_item.status_byte[3:0] & ST_COUNT_MASK;
        large_bit = i_item.status_byte[ST_LARGE_BIT];
        conf_eff  = (i_cfg.confirm_frames == 8'd0) ? 8'd1 : i_cfg.confirm_frames;

        // quiet gap only restarts the run while no touch is down
        gap     = i_item.now_ms - i_state.last_frame_time;
        gap_end = !i_state.held_down && (gap > {16'd0, i_cfg.gap_limit_ms});
        rej_gap = gap_end && (i_state.run_length != 8'd0) && (i_state.run_length < conf_eff);
        run_a   = gap_end ? 8'd0 : i_state.run_length;

        if (raw != 4'd0) begin
            run_b   = (run_a == RUN_MAX) ? RUN_MAX : run_a + 8'd1;
            rej_rel = 1'b0;
        end else begin
            run_b   = 8'd0;
            rej_rel = (run_a != 8'd0) && (run_a < conf_eff);
        end

        down = (run_b >= conf_eff);
        if (down) begin
            nx = i_cfg.rotate_half_turn ? mirror(i_item.point_x, i_cfg.rotate_max_x)
                                        : i_item.point_x;
            ny = i_cfg.rotate_half_turn ? mirror(i_item.point_y, i_cfg.rotate_max_y)
                                        : i_item.point_y;
            ns = i_item.point_size;
        end else begin
            nx = i_state.held_x;
            ny = i_state.held_y;
            ns = i_state.held_size;
        end

        chg = (nx != i_state.held_x) || (ny != i_state.held_y) ||
              (ns != i_state.held_size) || (down != i_state.held_down);

        o_state = i_state;
        if (fresh) begin
            o_state.run_length       = run_b;
            o_state.last_frame_time  = i_item.now_ms;
            o_state.held_x           = nx;
            o_state.held_y           = ny;
            o_state.held_size        = ns;
            o_state.held_down        = down;
            o_state.rejected_counter = i_state.rejected_counter +
                                       {31'd0, (rej_gap | rej_rel)};
            o_state.frame_counter    = i_state.frame_counter + 32'd1;
        end

        o_result.frame_taken    = fresh;
        o_result.changed        = fresh & chg;
        o_result.touch_down     = o_state.held_down;
        o_result.touch_x        = o_state.held_x;
        o_result.touch_y        = o_state.held_y;
        o_result.touch_size     = o_state.held_size;
        o_result.raw_count      = fresh ? raw : 4'd0;
        o_result.large_flag     = fresh & large_bit;
        o_result.rejected_total = o_state.rejected_counter;
        o_result.frames_total   = o_state.frame_counter;
    end

endmodule

### sv/tfcf_checker.sv
// ----------------------------------------------------------------------------
// tfcf_checker
// Port-level checks for the touch frame filter, bound to the top level.
// ----------------------------------------------------------------------------
module tfcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_frame_taken,
    input logic        o_changed,
    input logic [3:0]  o_raw_count,
    input logic        o_large_flag,
    input logic [31:0] o_frames_total
);

    // result beat waits while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frames_total))
        else $error("result beat dropped or changed under stall");

    // input side only backs up when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // a skipped frame reports no change and no status fields
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_taken |-> !o_changed && o_raw_count == 4'd0 && !o_large_flag)
        else $error("non-fresh frame shows activity");

    // nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind touch_frame_confirm_filter tfcf_checker u_tfcf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_frame_taken  (o_frame_taken),
    .o_changed      (o_changed),
    .o_raw_count    (o_raw_count),
    .o_large_flag   (o_large_flag),
    .o_frames_total (o_frames_total)
);

### test/tb_touch_frame_confirm_filter.sv
// ----------------------------------------------------------------------------
// tb_touch_frame_confirm_filter
// Self-checking bench: polled frames go in through a queue-fed driver, a
// built-in filter model predicts each result beat, and a monitor compares
// every field. Directed frames first, then random touch bursts with noise
// under several register settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_touch_frame_confirm_filter;
    import tfcf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_status_byte = '0;
    logic [31:0]            i_now_ms      = '0;
    logic [15:0]            i_point_x     = '0;
    logic [15:0]            i_point_y     = '0;
    logic [15:0]            i_point_size  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic                   o_frame_taken;
    logic                   o_changed;
    logic                   o_touch_down;
    logic [15:0]            o_touch_x;
    logic [15:0]            o_touch_y;
    logic [15:0]            o_touch_size;
    logic [3:0]             o_raw_count;
    logic                   o_large_flag;
    logic [31:0]            o_rejected_total;
    logic [31:0]            o_frames_total;

    touch_frame_confirm_filter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_status_byte    (i_status_byte),
        .i_now_ms         (i_now_ms),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_size     (i_point_size),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_taken    (o_frame_taken),
        .o_changed        (o_changed),
        .o_touch_down     (o_touch_down),
        .o_touch_x        (o_touch_x),
        .o_touch_y        (o_touch_y),
        .o_touch_size     (o_touch_size),
        .o_raw_count      (o_raw_count),
        .o_large_flag     (o_large_flag),
        .o_rejected_total (o_rejected_total),
        .o_frames_total   (o_frames_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cfg    regs;
    t_state  filt;
    t_item   poll_q[$];
    t_result report_q[$];
    t_item   cur_frame;
    logic [31:0] clock_ms;
    int frames_in_flight = 0;
    int err_cnt = 0;
    int cycle_count = 0;
    int src_gap_max = 0;
    int snk_stall_max = 0;
    int gap_left = 0;
    int stall_left = 0;

    // a run that ends short of the confirm count is a phantom
    function automatic void close_run(input logic [7:0] need);
        if (filt.run_length != 8'd0 && filt.run_length < need)
            filt.rejected_counter = filt.rejected_counter + 32'd1;
        filt.run_length = 8'd0;
    endfunction

    function automatic t_result filter_frame(input t_item f);
        t_result     r;
        logic [7:0]  need;
        logic [31:0] quiet;
        logic [15:0] nx, ny, ns;
        logic        nd;
        r = '0;
        need = (regs.confirm_frames == 8'd0) ? 8'd1 : regs.confirm_frames;
        if (f.status_byte[ST_FRESH_BIT]) begin
            r.frame_taken = 1'b1;
            r.raw_count = f.status_byte[3:0] & ST_COUNT_MASK;
            r.large_flag = f.status_byte[ST_LARGE_BIT];
            filt.frame_counter = filt.frame_counter + 32'd1;
            quiet = f.now_ms - filt.last_frame_time;
            if (!filt.held_down && quiet > {16'd0, regs.gap_limit_ms})
                close_run(need);
            filt.last_frame_time = f.now_ms;
            if (r.raw_count != 4'd0) begin
                if (filt.run_length != RUN_MAX)
                    filt.run_length = filt.run_length + 8'd1;
            end else begin
                close_run(need);
            end
            if (filt.run_length >= need) begin
                nd = 1'b1;
                nx = f.point_x;
                ny = f.point_y;
                if (regs.rotate_half_turn) begin
                    nx = (regs.rotate_max_x > f.point_x) ? regs.rotate_max_x - f.point_x : 16'd0;
                    ny = (regs.rotate_max_y > f.point_y) ? regs.rotate_max_y - f.point_y : 16'd0;
                end
                ns = f.point_size;
            end else begin
                nd = 1'b0;
                nx = filt.held_x;
                ny = filt.held_y;
                ns = filt.held_size;
            end
            r.changed = (nx != filt.held_x) || (ny != filt.held_y) ||
                        (ns != filt.held_size) || (nd != filt.held_down);
            filt.held_x = nx;
            filt.held_y = ny;
            filt.held_size = ns;
            filt.held_down = nd;
        end
        r.touch_down = filt.held_down;
        r.touch_x = filt.held_x;
        r.touch_y = filt.held_y;
        r.touch_size = filt.held_size;
        r.rejected_total = filt.rejected_counter;
        r.frames_total = filt.frame_counter;
        return r;
    endfunction

    function automatic void queue_frame(input logic [7:0] status, input logic [31:0] dt,
                                        input logic [15:0] x, input logic [15:0] y,
                                        input logic [15:0] sz);
        t_item f;
        clock_ms = clock_ms + dt;
        f.status_byte = status;
        f.now_ms = clock_ms;
        f.point_x = x;
        f.point_y = y;
        f.point_size = sz;
        poll_q.push_back(f);
        frames_in_flight++;
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // mostly inside the gap limit, with the boundary and restarts mixed in
    function automatic logic [31:0] pick_dt();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, regs.gap_limit_ms);
        if (r == 7)
            return regs.gap_limit_ms + 32'd1;
        if (r == 8)
            return {16'd0, regs.gap_limit_ms};
        return regs.gap_limit_ms + $urandom_range(2, 1000);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CONFIRM_FRAMES:   regs.confirm_frames = val[7:0];
            CFG_GAP_LIMIT_MS:     regs.gap_limit_ms = val;
            CFG_ROTATE_HALF_TURN: regs.rotate_half_turn = val[0];
            CFG_ROTATE_MAX_X:     regs.rotate_max_x = val;
            CFG_ROTATE_MAX_Y:     regs.rotate_max_y = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (frames_in_flight != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] confirm, input logic [15:0] gap,
                            input logic rot, input logic [15:0] mx, input logic [15:0] my);
        drain();
        // upper data bits of narrow registers must be ignored
        write_reg(CFG_CONFIRM_FRAMES, {8'($urandom), confirm});
        write_reg(CFG_GAP_LIMIT_MS, gap);
        write_reg(CFG_ROTATE_HALF_TURN, {15'($urandom), rot});
        write_reg(CFG_ROTATE_MAX_X, mx);
        write_reg(CFG_ROTATE_MAX_Y, my);
    endtask

    // touch bursts closed by a release, plus noise, stale polls and clock jumps
    task automatic random_session(input int n);
        int          pushed;
        int          kind;
        int          len;
        logic [7:0]  need;
        logic [7:0]  st;
        logic [15:0] bx, by, bs;
        pushed = 0;
        need = (regs.confirm_frames == 8'd0) ? 8'd1 : regs.confirm_frames;
        while (pushed < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 2) == 0)
                    len = $urandom_range(1, (need > 1) ? need - 1 : 1);
                else
                    len = need + $urandom_range(0, 4);
                bx = rand_coord();
                by = rand_coord();
                bs = rand_coord();
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) bx = rand_coord();
                    if ($urandom_range(0, 3) == 0) by = rand_coord();
                    if ($urandom_range(0, 3) == 0) bs = rand_coord();
                    st = 8'($urandom);
                    st[ST_FRESH_BIT] = 1'b1;
                    st[3:0] = 4'($urandom_range(1, 15));
                    queue_frame(st, pick_dt(), bx, by, bs);
                    if ($urandom_range(0, 9) == 0)
                        queue_frame({1'b0, 7'($urandom)}, pick_dt(), rand_coord(),
                                    rand_coord(), rand_coord());
                end
                st = 8'($urandom);
                st[ST_FRESH_BIT] = 1'b1;
                st[3:0] = 4'h0;
                queue_frame(st, pick_dt(), rand_coord(), rand_coord(), rand_coord());
                pushed += len + 1;
            end else if (kind == 6) begin
                queue_frame(8'($urandom), pick_dt(), rand_coord(), rand_coord(), rand_coord());
                pushed++;
            end else if (kind == 7) begin
                queue_frame({1'b0, 7'($urandom)}, pick_dt(), rand_coord(), rand_coord(),
                            rand_coord());
            end else if (kind == 8) begin
                queue_frame(8'($urandom), $urandom, rand_coord(), rand_coord(), rand_coord());
                pushed++;
            end else begin
                // land just below the wrap point so later deltas cross it
                queue_frame({1'b1, 7'($urandom)},
                            (32'hFFFF_FF00 + $urandom_range(0, 255)) - clock_ms,
                            rand_coord(), rand_coord(), rand_coord());
                pushed++;
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                report_q.push_back(filter_frame(cur_frame));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (poll_q.size() > 0) begin
                    cur_frame = poll_q.pop_front();
                    i_status_byte <= cur_frame.status_byte;
                    i_now_ms <= cur_frame.now_ms;
                    i_point_x <= cur_frame.point_x;
                    i_point_y <= cur_frame.point_y;
                    i_point_size <= cur_frame.point_size;
                    i_in_valid <= 1'b1;
                    gap_left = $urandom_range(0, src_gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_frame_taken, o_changed, o_touch_down, o_touch_x, o_touch_y,
                       o_touch_size, o_raw_count, o_large_flag, o_rejected_total,
                       o_frames_total};
                if (report_q.size() == 0) begin
                    $error("result beat with no frame pending");
                    err_cnt++;
                end else begin
                    want = report_q.pop_front();
                    frames_in_flight--;
                    check_field("frame_taken", want.frame_taken, got.frame_taken);
                    check_field("changed", want.changed, got.changed);
                    check_field("touch_down", want.touch_down, got.touch_down);
                    check_field("touch_x", want.touch_x, got.touch_x);
                    check_field("touch_y", want.touch_y, got.touch_y);
                    check_field("touch_size", want.touch_size, got.touch_size);
                    check_field("raw_count", want.raw_count, got.raw_count);
                    check_field("large_flag", want.large_flag, got.large_flag);
                    check_field("rejected_total", want.rejected_total, got.rejected_total);
                    check_field("frames_total", want.frames_total, got.frames_total);
                end
                stall_left = $urandom_range(0, snk_stall_max);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        filt = '0;
        regs = '0;
        regs.confirm_frames = CONFIRM_RESET;
        regs.gap_limit_ms = GAP_RESET;
        clock_ms = '0;
        src_gap_max = 3;
        snk_stall_max = 3;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: confirm after two frames, 40 ms gap, no rotation
        queue_frame(8'h7F, 100, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // stale poll
        queue_frame(8'hFF, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_frame(8'hB1, 10, 16'hFFFF, 16'h0000, 16'h1234);    // confirms
        queue_frame(8'h81, 40, 16'hFFFF, 16'h0000, 16'h1234);    // no change
        queue_frame(8'h82, 5000, 16'h0000, 16'hFFFF, 16'h0000);  // long gap while down
        queue_frame(8'h80, 10, 16'h1111, 16'h2222, 16'h3333);    // release
        queue_frame(8'hC0, 10, 16'h1111, 16'h2222, 16'h3333);
        queue_frame(8'h81, 10, 16'h0005, 16'h0006, 16'h0007);
        queue_frame(8'h80, 10, 16'h0005, 16'h0006, 16'h0007);    // short run rejected
        queue_frame(8'h81, 10, 16'h0005, 16'h0006, 16'h0007);
        queue_frame(8'h81, 41, 16'h0008, 16'h0009, 16'h000A);    // just over the gap
        queue_frame(8'h81, 40, 16'h0008, 16'h0009, 16'h000A);    // exactly at the gap
        queue_frame(8'h80, 1, 16'h0000, 16'h0000, 16'h0000);
        queue_frame(8'h8F, 32'hFFFF_FFF0 - clock_ms, 16'h0100, 16'h0200, 16'h0300);
        queue_frame(8'h83, 32'h20, 16'h0101, 16'h0201, 16'h0301); // timestamp wraps
        queue_frame(8'h00, 3, 16'hABCD, 16'hABCD, 16'hABCD);
        queue_frame(8'h80, 0, 16'h0000, 16'h0000, 16'h0000);

        // half-turn mirroring on both sides of the extent and at it
        set_regs(8'd1, GAP_RESET, 1'b1, 16'h8000, 16'hFFFF);
        queue_frame(8'h81, 10, 16'h7FFF, 16'h0000, 16'h0001);
        queue_frame(8'h81, 10, 16'h8000, 16'hFFFF, 16'h0002);
        queue_frame(8'h81, 10, 16'hFFFF, 16'h0001, 16'h0003);
        queue_frame(8'h80, 10, 16'h0000, 16'h0000, 16'h0000);
        queue_frame(8'hC1, 10, 16'h0000, 16'h8000, 16'hFFFF);

        set_regs(8'd1, 16'd0, 1'b1, 16'hFFFF, 16'h0000);
        src_gap_max = 0;
        snk_stall_max = 0;
        random_session(250);

        set_regs(8'd255, 16'hFFFF, 1'b0, 16'h0000, 16'hFFFF);
        src_gap_max = 7;
        snk_stall_max = 7;
        random_session(350);

        // zero confirm count behaves as one
        set_regs(8'd0, 16'd1, 1'b1, 16'($urandom), 16'($urandom));
        src_gap_max = 7;
        snk_stall_max = 0;
        random_session(200);

        for (int p = 0; p < 4; p++) begin
            set_regs(8'($urandom_range(1, (p == 3) ? 20 : 8)), 16'($urandom_range(0, 100)),
                     1'($urandom), rand_coord(), rand_coord());
            src_gap_max = (p == 0) ? 0 : $urandom_range(0, 7);
            snk_stall_max = (p == 1) ? 7 : $urandom_range(0, 7);
            random_session(200);
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (report_q.size() != 0) begin
            $error("%0d expected results never arrived", report_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
sv/tfcf_pkg.sv
sv/tfcf_cfg_regs.sv
sv/tfcf_update.sv
sv/touch_frame_confirm_filter.sv
sv/tfcf_checker.sv
test/tb_touch_frame_confirm_filter.sv
